// ===== src/grid_mark_weighted_dilation_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the occupancy grid block
// Shared forms of the concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GRID_MARK_WEIGHTED_DILATION_MACROS_SVH
`define GRID_MARK_WEIGHTED_DILATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMWD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gmwd_pkg.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid package
// Sizes, request codes, register indexes and item types of the grid block.
// ----------------------------------------------------------------------------
package gmwd_pkg;

  localparam int MAP_SIDE      = 256;
  localparam int KERNEL_RADIUS = 4;

  localparam int KDIAM      = 2 * KERNEL_RADIUS + 1;
  localparam int KIDX_W     = $clog2(KDIAM);
  localparam int DIST_W     = $clog2(KERNEL_RADIUS + 1);
  localparam int ADDR_W     = $clog2(MAP_SIDE);
  localparam int SIDE_W     = $clog2(MAP_SIDE + 1);
  localparam int CFG_SIDE_W = 9;
  localparam int CMP_W      = (SIDE_W > CFG_SIDE_W) ? SIDE_W : CFG_SIDE_W;
  localparam int COORD_W    = CMP_W + 2;

  localparam int PT_W    = 16;
  localparam int HALF_W  = 16;
  localparam int SH_W    = PT_W + 2;
  localparam int MUL_A_W = PT_W + 1;
  localparam int INV_W   = 21;
  localparam int PROD_W  = MUL_A_W + INV_W;
  localparam int FRAC_W  = 20;
  localparam int CELL_W  = PROD_W - FRAC_W;

  localparam int WH_W   = 8;
  localparam int COST_W = 7;
  localparam int IDX_W  = 8;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_MARK  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [2:0] REG_MAP_SIDE    = 3'd0;
  localparam logic [2:0] REG_HALF_EXTENT = 3'd1;
  localparam logic [2:0] REG_INV_CELL    = 3'd2;
  localparam logic [2:0] REG_WINDOW_HALF = 3'd3;
  localparam logic [2:0] REG_PEAK_WEIGHT = 3'd4;
  localparam logic [2:0] REG_RING_STEP   = 3'd5;

  localparam logic [CFG_SIDE_W-1:0] RST_MAP_SIDE    = 9'd200;
  localparam logic [HALF_W-1:0]     RST_HALF_EXTENT = 16'd30000;
  localparam logic [INV_W-1:0]      RST_INV_CELL    = 21'd3495;
  localparam logic [WH_W-1:0]       RST_WINDOW_HALF = 8'd20;
  localparam logic [COST_W-1:0]     RST_PEAK_WEIGHT = 7'd100;
  localparam logic [COST_W-1:0]     RST_RING_STEP   = 7'd20;

  typedef struct packed {
    logic [1:0]             req_type;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic [IDX_W-1:0]       query_row;
    logic [IDX_W-1:0]       query_col;
  } req_t;

  typedef struct packed {
    logic [COST_W-1:0] cell_cost;
    logic              in_window;
  } rsp_t;

endpackage

// ===== src/gmwd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gmwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/grid_mark_weighted_dilation.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid with weighted max dilation
// Marks planar points in a square bitmap and answers kernel cost queries.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready, req) takes clear, mark and query
// items; only a query gives a result item on the response channel (rsp_valid,
// rsp_ready, rsp). Registers are to be written through the APB port only while
// idle; the block itself does not enforce this. The bitmap is a RAM of
// MAP_SIDE rows, each one row of cells wide. A clear item sweeps all MAP_SIDE
// rows of the RAM, one row a cycle. A mark item passes S_MARK_X, S_MARK_Y and
// S_MARK_CHK: both coordinates go through one shared multiplier in turn, then
// the row is read; if the cell lies in the map, S_MARK_WR sets the bit and
// writes the row back. A query inside the window walks the 9 by 9 kernel: each
// kernel row takes a RAM read (S_Q_RD), a load of the picked columns (S_Q_LOAD)
// and the kernel columns in turn on the shared weight unit (S_Q_EVAL). A query
// outside the window goes straight to S_Q_DONE. The block takes the next item
// while a result still waits in the output register; if the receiver stalls, a
// finished query waits until it is free. Reset loads the register defaults and
// runs the same clearing sweep, during which req_ready stays low.
// ----------------------------------------------------------------------------
module grid_mark_weighted_dilation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  gmwd_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output gmwd_pkg::rsp_t                  rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gmwd_pkg::PADDR_W-1:0]    paddr,
  input  logic [gmwd_pkg::PDATA_W-1:0]    pwdata,
  output logic [gmwd_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  import gmwd_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_MARK_X   = 10'b00_0000_0100,
    S_MARK_Y   = 10'b00_0000_1000,
    S_MARK_CHK = 10'b00_0001_0000,
    S_MARK_WR  = 10'b00_0010_0000,
    S_Q_RD     = 10'b00_0100_0000,
    S_Q_LOAD   = 10'b00_1000_0000,
    S_Q_EVAL   = 10'b01_0000_0000,
    S_Q_DONE   = 10'b10_0000_0000
  } state_t;

  localparam logic signed [COORD_W-1:0] KR_S   = COORD_W'(KERNEL_RADIUS);
  localparam logic [KIDX_W-1:0]         KR_IDX = KIDX_W'(KERNEL_RADIUS);
  localparam logic [KIDX_W-1:0]         K_LAST = KIDX_W'(KDIAM - 1);

  state_t state;
  state_t state_next;

  logic [CFG_SIDE_W-1:0] map_side_used;
  logic [HALF_W-1:0]     half_extent_mm;
  logic [INV_W-1:0]      inv_cell_size_q20;
  logic [WH_W-1:0]       window_half;
  logic [COST_W-1:0]     peak_weight;
  logic [COST_W-1:0]     ring_step;

  logic [ADDR_W-1:0]      clr_row;
  logic signed [PT_W-1:0] mx;
  logic signed [PT_W-1:0] my;
  logic                   neg_x;
  logic                   neg_y;
  logic                   cx_ok;
  logic [ADDR_W-1:0]      cx;
  logic [ADDR_W-1:0]      mark_row;
  logic [PROD_W-1:0]      prod;
  logic [IDX_W-1:0]       q_row;
  logic [IDX_W-1:0]       q_col;
  logic [KIDX_W-1:0]      row_idx;
  logic [KIDX_W-1:0]      col_idx;
  logic [COST_W-1:0]      best;
  logic                   q_inside;
  logic [KDIAM-1:0]       win;

  logic                        ram_wr_en;
  logic [ADDR_W-1:0]           ram_wr_addr;
  logic [MAP_SIDE-1:0]         ram_wr_data;
  logic                        ram_rd_en;
  logic [ADDR_W-1:0]           ram_rd_addr;
  logic [MAP_SIDE-1:0]         ram_rd_data;
  logic [MAP_SIDE-1:0]         mark_data;

  logic [CMP_W-1:0]            msu_w;
  logic [CMP_W-1:0]            side_c;
  logic signed [COORD_W-1:0]   side_s;
  logic signed [COORD_W-1:0]   mid_s;
  logic signed [COORD_W-1:0]   lo_s;
  logic signed [COORD_W-1:0]   hi_s;
  logic signed [COORD_W-1:0]   qr_s;
  logic signed [COORD_W-1:0]   qc_s;
  logic                        in_win;
  logic signed [COORD_W-1:0]   kr_s;
  logic                        row_ok;
  logic [KDIAM-1:0]            win_c;

  logic signed [SH_W-1:0]      sx;
  logic signed [SH_W-1:0]      sy;
  logic [MUL_A_W-1:0]          mul_a;
  logic [CELL_W-1:0]           cell_idx;
  logic                        cell_ok;
  logic                        cy_ok;

  logic [DIST_W-1:0]           ring_dist;
  logic [COST_W+DIST_W-1:0]    step_prod;
  logic [COST_W+DIST_W-1:0]    peak_ext;
  logic [COST_W-1:0]           weight;

  logic                        cfg_wr;
  logic [2:0]                  cfg_idx;
  logic                        rsp_load;

  function automatic logic [DIST_W-1:0] kdist(input logic [KIDX_W-1:0] i,
                                              input logic [KIDX_W-1:0] j);
    logic [KIDX_W-1:0] ai;
    logic [KIDX_W-1:0] aj;
    ai = (i >= KR_IDX) ? i - KR_IDX : KR_IDX - i;
    aj = (j >= KR_IDX) ? j - KR_IDX : KR_IDX - j;
    return DIST_W'((ai > aj) ? ai : aj);
  endfunction

  // Side in use, clamped to the bitmap, and the central window around it.
  always_comb begin
    msu_w = CMP_W'(map_side_used);
    if (msu_w == '0) begin
      side_c = CMP_W'(1);
    end else if (msu_w > CMP_W'(MAP_SIDE)) begin
      side_c = CMP_W'(MAP_SIDE);
    end else begin
      side_c = msu_w;
    end
    side_s = signed'(COORD_W'(side_c));
    mid_s  = side_s >>> 1;
    lo_s   = mid_s - signed'(COORD_W'(window_half));
    hi_s   = mid_s + signed'(COORD_W'(window_half));
    qr_s   = signed'(COORD_W'(req.query_row));
    qc_s   = signed'(COORD_W'(req.query_col));
    in_win = (qr_s >= lo_s) && (qr_s < hi_s) && (qc_s >= lo_s) && (qc_s < hi_s) &&
             (qr_s < side_s) && (qc_s < side_s);
  end

  // Kernel row being visited and the kernel columns picked out of it.
  always_comb begin
    logic signed [COORD_W-1:0] cc;
    kr_s   = signed'(COORD_W'(q_row)) + signed'(COORD_W'(row_idx)) - KR_S;
    row_ok = !kr_s[COORD_W-1] && (kr_s < side_s);
    for (int k = 0; k < KDIAM; k++) begin
      cc       = signed'(COORD_W'(q_col)) + signed'(COORD_W'(k)) - KR_S;
      win_c[k] = row_ok && !cc[COORD_W-1] && (cc < side_s) &&
                 ram_rd_data[cc[ADDR_W-1:0]];
    end
  end

  // Shared multiplier for both point coordinates.
  always_comb begin
    sx       = SH_W'(mx) + signed'(SH_W'(half_extent_mm));
    sy       = SH_W'(my) + signed'(SH_W'(half_extent_mm));
    mul_a    = (state == S_MARK_X) ? sx[MUL_A_W-1:0] : sy[MUL_A_W-1:0];
    cell_idx = prod[PROD_W-1:FRAC_W];
    cell_ok  = cell_idx < CELL_W'(side_c);
    cy_ok    = !neg_y && cell_ok;
  end

  // Shared weight unit: one kernel cell a cycle.
  always_comb begin
    ring_dist = kdist(row_idx, col_idx);
    step_prod = (COST_W + DIST_W)'(ring_step) * (COST_W + DIST_W)'(ring_dist);
    peak_ext  = (COST_W + DIST_W)'(peak_weight);
    weight    = (step_prod >= peak_ext) ? '0 : COST_W'(peak_ext - step_prod);
  end

  always_comb begin
    mark_data     = ram_rd_data;
    mark_data[cx] = 1'b1;
    ram_wr_en     = (state == S_CLEAR) || (state == S_MARK_WR);
    ram_wr_addr   = (state == S_CLEAR) ? clr_row : mark_row;
    ram_wr_data   = (state == S_CLEAR) ? '0 : mark_data;
    ram_rd_en     = (state == S_Q_RD) || (state == S_MARK_CHK);
    ram_rd_addr   = (state == S_Q_RD) ? kr_s[ADDR_W-1:0] : cell_idx[ADDR_W-1:0];
  end

  gmwd_ram #(
    .WIDTH (MAP_SIDE),
    .DEPTH (MAP_SIDE)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign req_ready = (state == S_IDLE);
  assign rsp_load  = (state == S_Q_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_row == ADDR_W'(MAP_SIDE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.req_type)
            REQ_CLEAR: state_next = S_CLEAR;
            REQ_MARK:  state_next = S_MARK_X;
            REQ_QUERY: state_next = in_win ? S_Q_RD : S_Q_DONE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_MARK_X:   state_next = S_MARK_Y;
      S_MARK_Y:   state_next = S_MARK_CHK;
      S_MARK_CHK: state_next = (cx_ok && cy_ok) ? S_MARK_WR : S_IDLE;
      S_MARK_WR:  state_next = S_IDLE;
      S_Q_RD:     state_next = S_Q_LOAD;
      S_Q_LOAD:   state_next = S_Q_EVAL;
      S_Q_EVAL: begin
        if (col_idx == K_LAST) begin
          state_next = (row_idx == K_LAST) ? S_Q_DONE : S_Q_RD;
        end
      end
      S_Q_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
      row_idx <= '0;
      col_idx <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_row <= clr_row + ADDR_W'(1);
      end else begin
        clr_row <= '0;
      end
      if (state == S_IDLE) begin
        row_idx <= '0;
        col_idx <= '0;
      end else if (state == S_Q_EVAL) begin
        if (col_idx == K_LAST) begin
          col_idx <= '0;
          row_idx <= row_idx + KIDX_W'(1);
        end else begin
          col_idx <= col_idx + KIDX_W'(1);
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      mx       <= req.point_x;
      my       <= req.point_y;
      q_row    <= req.query_row;
      q_col    <= req.query_col;
      q_inside <= in_win;
      best     <= '0;
    end
    if (state == S_MARK_X || state == S_MARK_Y) begin
      prod <= PROD_W'(mul_a) * PROD_W'(inv_cell_size_q20);
    end
    if (state == S_MARK_X) begin
      neg_x <= sx[SH_W-1];
    end
    if (state == S_MARK_Y) begin
      cx_ok <= !neg_x && cell_ok;
      cx    <= cell_idx[ADDR_W-1:0];
      neg_y <= sy[SH_W-1];
    end
    if (state == S_MARK_CHK) begin
      mark_row <= cell_idx[ADDR_W-1:0];
    end
    if (state == S_Q_LOAD) begin
      win <= win_c;
    end
    if (state == S_Q_EVAL && win[col_idx] && weight > best) begin
      best <= weight;
    end
    if (rsp_load) begin
      rsp.cell_cost <= best;
      rsp.in_window <= q_inside;
    end
  end

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_side_used     <= RST_MAP_SIDE;
      half_extent_mm    <= RST_HALF_EXTENT;
      inv_cell_size_q20 <= RST_INV_CELL;
      window_half       <= RST_WINDOW_HALF;
      peak_weight       <= RST_PEAK_WEIGHT;
      ring_step         <= RST_RING_STEP;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAP_SIDE:    map_side_used     <= pwdata[CFG_SIDE_W-1:0];
        REG_HALF_EXTENT: half_extent_mm    <= pwdata[HALF_W-1:0];
        REG_INV_CELL:    inv_cell_size_q20 <= pwdata[INV_W-1:0];
        REG_WINDOW_HALF: window_half       <= pwdata[WH_W-1:0];
        REG_PEAK_WEIGHT: peak_weight       <= pwdata[COST_W-1:0];
        REG_RING_STEP:   ring_step         <= pwdata[COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MAP_SIDE:    prdata = PDATA_W'(map_side_used);
      REG_HALF_EXTENT: prdata = PDATA_W'(half_extent_mm);
      REG_INV_CELL:    prdata = PDATA_W'(inv_cell_size_q20);
      REG_WINDOW_HALF: prdata = PDATA_W'(window_half);
      REG_PEAK_WEIGHT: prdata = PDATA_W'(peak_weight);
      REG_RING_STEP:   prdata = PDATA_W'(ring_step);
      default:         prdata = '0;
    endcase
  end

`include "grid_mark_weighted_dilation_macros.svh"

  `GMWD_ASSERT_IMPLY(a_clear_writes_zero, state == S_CLEAR,
                     ram_wr_en && ram_wr_data == '0, "clear sweep must write empty rows")
  `GMWD_ASSERT_NEXT(a_query_starts, req_valid && req_ready && req.req_type == REQ_QUERY,
                    state == S_Q_RD || state == S_Q_DONE, "query item did not start")
  `GMWD_ASSERT_IMPLY(a_rsp_from_query, $rose(rsp_valid),
                     $past(state) == S_Q_DONE, "result item without a finished query")
  `GMWD_ASSERT_IMPLY(a_mark_in_map, state == S_MARK_WR,
                     CMP_W'(cx) < side_c, "mark written outside the map in use")

endmodule

// ===== sim/grid_mark_weighted_dilation_tb.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid with weighted max dilation: testbench
// Drives clear, mark and query items through the request channel, tracks the
// bitmap and the registers on the side, and compares every query answer with
// the cost worked out here. Register settings change between phases only
// while the block is idle.
// ----------------------------------------------------------------------------
module grid_mark_weighted_dilation_tb;
  import gmwd_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 2000000;

  class occupancy_costs;
    bit occ [MAP_SIDE*MAP_SIDE];
    logic [8:0] side_reg;
    logic [15:0] half_mm;
    logic [20:0] inv_q20;
    logic [7:0] win_half;
    logic [6:0] peak_w;
    logic [6:0] ring_w;
    rsp_t pending_costs[$];
    int failures;
    int costs_checked;
    int cells_marked;
    int clears;

    function new();
      side_reg = RST_MAP_SIDE;
      half_mm = RST_HALF_EXTENT;
      inv_q20 = RST_INV_CELL;
      win_half = RST_WINDOW_HALF;
      peak_w = RST_PEAK_WEIGHT;
      ring_w = RST_RING_STEP;
      failures = 0;
      costs_checked = 0;
      cells_marked = 0;
      clears = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_MAP_SIDE: side_reg = value[8:0];
        REG_HALF_EXTENT: half_mm = value[15:0];
        REG_INV_CELL: inv_q20 = value[20:0];
        REG_WINDOW_HALF: win_half = value[7:0];
        REG_PEAK_WEIGHT: peak_w = value[6:0];
        REG_RING_STEP: ring_w = value[6:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_MAP_SIDE: return 32'(side_reg);
        REG_HALF_EXTENT: return 32'(half_mm);
        REG_INV_CELL: return 32'(inv_q20);
        REG_WINDOW_HALF: return 32'(win_half);
        REG_PEAK_WEIGHT: return 32'(peak_w);
        REG_RING_STEP: return 32'(ring_w);
        default: return '0;
      endcase
    endfunction

    function int side_used();
      if (side_reg < 1) return 1;
      if (side_reg > MAP_SIDE) return MAP_SIDE;
      return int'(side_reg);
    endfunction

    // A coordinate that lands below zero or past the side in use gives -1.
    function int cell_of(logic signed [15:0] mm);
      longint shifted;
      longint cidx;
      shifted = longint'(mm) + longint'(half_mm);
      if (shifted < 0) return -1;
      cidx = (shifted * longint'(inv_q20)) >> 20;
      if (cidx >= side_used()) return -1;
      return int'(cidx);
    endfunction

    function rsp_t cost_at(int r, int c);
      rsp_t res;
      int s, lo, hi, best, ar, ac, d, w, rr, cc;
      res = '0;
      s = side_used();
      lo = s / 2 - int'(win_half);
      hi = s / 2 + int'(win_half);
      if (r < lo || r >= hi || c < lo || c >= hi || r >= s || c >= s) return res;
      best = 0;
      for (int dr = -KERNEL_RADIUS; dr <= KERNEL_RADIUS; dr++) begin
        for (int dc = -KERNEL_RADIUS; dc <= KERNEL_RADIUS; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if (rr >= 0 && cc >= 0 && rr < s && cc < s && occ[rr*MAP_SIDE+cc]) begin
            ar = dr < 0 ? -dr : dr;
            ac = dc < 0 ? -dc : dc;
            d = ar > ac ? ar : ac;
            w = int'(peak_w) - int'(ring_w) * d;
            if (w < 0) w = 0;
            if (w > best) best = w;
          end
        end
      end
      res.cell_cost = best[6:0];
      res.in_window = 1'b1;
      return res;
    endfunction

    function void note_item(req_t it);
      int cx, cy;
      case (it.req_type)
        REQ_CLEAR: begin
          foreach (occ[i]) occ[i] = 1'b0;
          clears++;
        end
        REQ_MARK: begin
          cx = cell_of(it.point_x);
          cy = cell_of(it.point_y);
          if (cx >= 0 && cy >= 0) begin
            occ[cy*MAP_SIDE+cx] = 1'b1;
            cells_marked++;
          end
        end
        REQ_QUERY: pending_costs = {pending_costs, cost_at(it.query_row, it.query_col)};
        default: ;
      endcase
    endfunction

    function void check_cost(rsp_t got);
      rsp_t want;
      if (pending_costs.size() == 0) begin
        $error("unexpected result: cell_cost %0d, in_window %0d", got.cell_cost,
               got.in_window);
        failures++;
        return;
      end
      want = pending_costs.pop_front();
      costs_checked++;
      if (got.cell_cost !== want.cell_cost) begin
        $error("cell_cost: expected %0d, got %0d", want.cell_cost, got.cell_cost);
        failures++;
      end
      if (got.in_window !== want.in_window) begin
        $error("in_window: expected %0d, got %0d", want.in_window, got.in_window);
        failures++;
      end
    endfunction

    function int pending();
      return pending_costs.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  occupancy_costs grid;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_tog = 1'b0;
  int items_sent = 0;
  int settings_used = 0;
  int hot_r[$];
  int hot_c[$];

  grid_mark_weighted_dilation u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $error("timeout after %0d cycles", CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // The receiver stalls at random and, when asked, holds off for a long
  // stretch so that the block backs up into its request channel.
  initial begin : rsp_side
    int hold_left;
    logic seen_tog;
    hold_left = 0;
    seen_tog = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) grid.check_cost(rsp);
      if (hold_tog != seen_tog) begin
        seen_tog = hold_tog;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(req_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    grid.note_item(it);
    items_sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (grid.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each write is read back at once; psel stays high between the two.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    grid.set_reg(idx, value);
    want = grid.reg_value(idx);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("register %0d: expected %0h, got %0h", idx, want, prdata);
      grid.failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t mk_item(logic [1:0] kind, int x, int y, int r, int c);
    req_t it;
    it.req_type = kind;
    it.point_x = x[15:0];
    it.point_y = y[15:0];
    it.query_row = r[7:0];
    it.query_col = c[7:0];
    return it;
  endfunction

  // Picks a point in millimetres that falls in or next to the given cell.
  function automatic logic signed [15:0] mm_for_cell(int target);
    longint num, mm;
    logic [31:0] rnd;
    rnd = $urandom;
    if (grid.inv_q20 == 0) return rnd[15:0];
    num = (longint'(target) <<< 20) + longint'($urandom_range(0, 1048575));
    mm = num / longint'(grid.inv_q20) - longint'(grid.half_mm);
    if (mm > 32767) mm = 32767;
    if (mm < -32768) mm = -32768;
    return mm[15:0];
  endfunction

  function automatic logic [7:0] jitter(int h);
    int v;
    v = h + int'($urandom_range(0, 10)) - 5;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Most marks land around the window and most queries fall near cells that
  // were marked recently, others around the window; the rest spans the full range.
  function automatic req_t next_item();
    req_t it;
    logic [31:0] rnd;
    int pick, lo, hi, k, cx, cy;
    rnd = $urandom;
    it.point_x = rnd[15:0];
    it.point_y = rnd[31:16];
    rnd = $urandom;
    it.query_row = rnd[7:0];
    it.query_col = rnd[15:8];
    it.req_type = rnd[17:16];
    pick = $urandom_range(0, 99);
    lo = grid.side_used() / 2 - int'(grid.win_half) - KERNEL_RADIUS - 1;
    hi = grid.side_used() / 2 + int'(grid.win_half) + KERNEL_RADIUS;
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    if (pick < 3) begin
      it.req_type = REQ_CLEAR;
      hot_r.delete();
      hot_c.delete();
    end else if (pick < 6) begin
      it.req_type = REQ_UNUSED;
    end else if (pick < 50) begin
      it.req_type = REQ_MARK;
      if (pick < 39) begin
        it.point_x = mm_for_cell($urandom_range(lo, hi));
        it.point_y = mm_for_cell($urandom_range(lo, hi));
      end
      cx = grid.cell_of(it.point_x);
      cy = grid.cell_of(it.point_y);
      if (cx >= 0 && cy >= 0) begin
        hot_r = {hot_r, cy};
        hot_c = {hot_c, cx};
        if (hot_r.size() > 16) begin
          void'(hot_r.pop_front());
          void'(hot_c.pop_front());
        end
      end
    end else begin
      it.req_type = REQ_QUERY;
      if (pick < 80 && hot_r.size() > 0) begin
        k = $urandom_range(0, hot_r.size() - 1);
        it.query_row = jitter(hot_r[k]);
        it.query_col = jitter(hot_c[k]);
      end else if (pick < 92) begin
        it.query_row = 8'($urandom_range(lo, hi));
        it.query_col = 8'($urandom_range(lo, hi));
      end
    end
    return it;
  endfunction

  // Runs against the reset register values: window rows and columns 80..119,
  // the origin point lands in cell 99 on both axes.
  task automatic run_directed();
    req_t dir_items[$];
    dir_items = {
      mk_item(REQ_QUERY, 0, 0, 100, 100),
      mk_item(REQ_MARK, 0, 0, 0, 0),
      mk_item(REQ_MARK, -32768, -32768, 0, 0),
      mk_item(REQ_MARK, 32767, 32767, 0, 0),
      mk_item(REQ_MARK, -30000, -30000, 0, 0),
      mk_item(REQ_MARK, 0, 32767, 0, 0),
      mk_item(REQ_MARK, -30000, 0, 0, 0),
      mk_item(REQ_QUERY, 0, 0, 99, 99),
      mk_item(REQ_QUERY, 0, 0, 95, 95),
      mk_item(REQ_QUERY, 0, 0, 99, 104),
      mk_item(REQ_QUERY, 0, 0, 103, 102),
      mk_item(REQ_QUERY, 0, 0, 0, 0),
      mk_item(REQ_QUERY, 0, 0, 255, 255),
      mk_item(REQ_QUERY, 0, 0, 79, 100),
      mk_item(REQ_QUERY, 0, 0, 80, 80),
      mk_item(REQ_QUERY, 0, 0, 119, 119),
      mk_item(REQ_QUERY, 0, 0, 120, 119),
      mk_item(REQ_UNUSED, -1, -1, 255, 255),
      mk_item(REQ_MARK, -1, -1, 0, 0),
      mk_item(REQ_QUERY, 0, 0, 99, 100),
      mk_item(REQ_CLEAR, 0, 0, 0, 0),
      mk_item(REQ_QUERY, 0, 0, 99, 99)
    };
    foreach (dir_items[i]) send_item(dir_items[i]);
  endtask

  task automatic run_phase(int side, int half, int inv, int wh, int peak, int ring,
                           int items, int hold_at);
    req_t it;
    int counted;
    wait_idle();
    write_reg(REG_MAP_SIDE, side);
    write_reg(REG_HALF_EXTENT, half);
    write_reg(REG_INV_CELL, inv);
    write_reg(REG_WINDOW_HALF, wh);
    write_reg(REG_PEAK_WEIGHT, peak);
    write_reg(REG_RING_STEP, ring);
    settings_used++;
    counted = 0;
    while (counted < items) begin
      if (counted == hold_at) hold_tog <= ~hold_tog;
      it = next_item();
      send_item(it);
      if (it.req_type != REQ_UNUSED) counted++;
    end
  endtask

  initial begin : main_seq
    grid = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // The block clears its bitmap after reset before it takes any item.
    repeat (SETTLE_CYCLES) @(posedge clk);
    send_idle_pct = 12;
    recv_idle_pct = 86;
    run_directed();
    run_phase(200, 30000, 3495, 20, 100, 20, 160, 60);
    run_phase(256, 0, 1048576, 128, 127, 0, 160, -1);
    send_idle_pct = 86;
    recv_idle_pct = 12;
    run_phase(511, 65535, 1, 128, 127, 127, 160, -1);
    run_phase(0, 1000, 0, 1, 50, 10, 160, -1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(64, 5000, 52429, 40, 127, 1, 160, -1);
    run_phase($urandom_range(8, 256), $urandom_range(0, 65535), $urandom_range(2000, 300000),
              $urandom_range(0, 64), $urandom_range(0, 127), $urandom_range(0, 127), 160, -1);
    run_phase(200, 30000, 3495, 0, 100, 20, 30, -1);
    wait_idle();
    $display("run covered %0d items under %0d register settings, %0d costs checked",
             items_sent, settings_used, grid.costs_checked);
    $display("marks that hit the map: %0d, clears: %0d", grid.cells_marked, grid.clears);
    if (grid.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/gmwd_pkg.sv
src/gmwd_ram.sv
src/grid_mark_weighted_dilation.sv
sim/grid_mark_weighted_dilation_tb.sv
